// File: hw/rtl/sact_pkg.sv
// Package for the set-associative cache tag lookup block.
// Holds parameters defaults, register indexes and the sequencer state type.
`default_nettype none
package sact_pkg;
	localparam int MAX_SETS_DEF   = 64;
	localparam int MAX_WAYS_DEF   = 8;
	localparam int STAMP_BITS_DEF = 32;

	localparam logic [1:0] REG_BLOCK_BYTES = 2'd0;
	localparam logic [1:0] REG_SET_COUNT   = 2'd1;
	localparam logic [1:0] REG_WAYS        = 2'd2;
	localparam logic [1:0] REG_POLICY      = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_MOD,
		ST_RD,
		ST_SCAN,
		ST_WRITE,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

// File: hw/rtl/set_assoc_cache_tag_lookup_top.sv
// Set-associative cache tag lookup, top level.
// Depends on sact_pkg.
//
// One access runs a bit-serial division by the block size, a bit-serial modulo by the set
// count, a read of the first way, a scan of the ways (each way is read from the line memory
// in turn), a write and the output hand-off; the block is not ready while an item is at work.
// After reset a clearing pass over all MAX_SETS*MAX_WAYS lines marks every line invalid
// before the first item is taken; configuration writes are taken during it.
`default_nettype none
module set_assoc_cache_tag_lookup_top #(
	parameter int MAX_SETS   = sact_pkg::MAX_SETS_DEF,
	parameter int MAX_WAYS   = sact_pkg::MAX_WAYS_DEF,
	parameter int STAMP_BITS = sact_pkg::STAMP_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // byte_address[31:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// was_hit[0], set_number[6:1], way_number[9:7], block_tag[41:10],
	// hit_total[73:42], miss_total[105:74], zero fill [111:106]
	output logic      [111:0] m_tdata
);
	localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int LINES = MAX_SETS * MAX_WAYS;
	localparam int AW = SW + WW;
	localparam int LW = 1 + 32 + 2 * STAMP_BITS;

	// configuration registers
	logic [12:0] block_bytes_q;
	logic [6:0]  set_count_q;
	logic [3:0]  ways_q;
	logic        policy_q;

	assign pready = 1'b1;
	wire cfg_wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= 13'd16;
			set_count_q   <= 7'd16;
			ways_q        <= 4'd4;
			policy_q      <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				sact_pkg::REG_BLOCK_BYTES: block_bytes_q <= pwdata[12:0];
				sact_pkg::REG_SET_COUNT:   set_count_q   <= pwdata[6:0];
				sact_pkg::REG_WAYS:        ways_q        <= pwdata[3:0];
				sact_pkg::REG_POLICY:      policy_q      <= pwdata[0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr[3:2])
			sact_pkg::REG_BLOCK_BYTES: prdata = {19'd0, block_bytes_q};
			sact_pkg::REG_SET_COUNT:   prdata = {25'd0, set_count_q};
			sact_pkg::REG_WAYS:        prdata = {28'd0, ways_q};
			sact_pkg::REG_POLICY:      prdata = {31'd0, policy_q};
			default:                   prdata = 32'd0;
		endcase
	end

	// effective divisors and way count
	wire [12:0] div_eff = (block_bytes_q == 13'd0) ? 13'd1 : block_bytes_q;
	logic [12:0] sets_eff;
	logic [5:0]  ways_eff;
	always_comb begin
		sets_eff = (set_count_q == 7'd0) ? 13'd1 : {6'd0, set_count_q};
		if (sets_eff > 13'(MAX_SETS)) sets_eff = 13'(MAX_SETS);
		ways_eff = (ways_q == 4'd0) ? 6'd1 : {2'd0, ways_q};
		if (ways_eff > 6'(MAX_WAYS)) ways_eff = 6'(MAX_WAYS);
	end

	// line memory: {valid, tag, age, insert}
	logic [LW-1:0] mem [LINES];
	logic [LW-1:0] rd_data_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [LW-1:0] mem_wdata;
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_data_q <= mem[mem_raddr];
	end

	sact_pkg::state_t state_q, state_d;
	logic [AW:0]   clr_q;
	logic [5:0]    cnt_q;       // bit counter and way counter
	logic [31:0]   quo_q;       // dividend shifts out, quotient shifts in
	logic [31:0]   rem_q;
	logic [31:0]   tag_q;
	logic [SW-1:0] set_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic          hit_q, found_q;
	logic [WW-1:0] pick_q;
	logic [STAMP_BITS-1:0] best_q;
	logic [31:0]   hits_q, misses_q;
	logic [111:0]  out_q;
	// insertion stamp of the hit line, kept for the age refresh
	logic [STAMP_BITS-1:0] rins_hold_q;

	wire [AW-1:0] rd_idx = {set_q, cnt_q[WW-1:0]};
	wire [WW-1:0] way_cur = WW'(cnt_q - 6'd1);
	wire          rv   = rd_data_q[LW-1];
	wire [31:0]   rtag = rd_data_q[LW-2 -: 32];
	wire [STAMP_BITS-1:0] rage = rd_data_q[2*STAMP_BITS-1 -: STAMP_BITS];
	wire [STAMP_BITS-1:0] rins = rd_data_q[STAMP_BITS-1:0];
	wire [STAMP_BITS-1:0] rkey = policy_q ? rins : rage;
	wire [32:0] rem_sh = {rem_q, quo_q[31]};
	wire [32:0] rem_sub = rem_sh - {20'd0, (state_q == sact_pkg::ST_DIV) ? div_eff : sets_eff};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sact_pkg::ST_CLEAR: if (clr_q == (AW+1)'(LINES - 1)) state_d = sact_pkg::ST_IDLE;
			sact_pkg::ST_IDLE:  if (s_tvalid) state_d = sact_pkg::ST_DIV;
			sact_pkg::ST_DIV:   if (cnt_q == 6'd31) state_d = sact_pkg::ST_MOD;
			sact_pkg::ST_MOD:   if (cnt_q == 6'd31) state_d = sact_pkg::ST_RD;
			sact_pkg::ST_RD:    state_d = sact_pkg::ST_SCAN;
			sact_pkg::ST_SCAN:  if (cnt_q == ways_eff) state_d = sact_pkg::ST_WRITE;
			sact_pkg::ST_WRITE: state_d = sact_pkg::ST_OUT;
			sact_pkg::ST_OUT:   if (m_tready) state_d = sact_pkg::ST_IDLE;
			default:            state_d = sact_pkg::ST_IDLE;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		s_tready  = (state_q == sact_pkg::ST_IDLE);
		m_tvalid  = (state_q == sact_pkg::ST_OUT);
		m_tdata   = out_q;
		mem_raddr = rd_idx;
		mem_we    = 1'b0;
		mem_waddr = {set_q, pick_q};
		mem_wdata = {1'b1, tag_q, stamp_q, stamp_q};
		if (state_q == sact_pkg::ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q[AW-1:0];
			mem_wdata = '0;
		end else if (state_q == sact_pkg::ST_WRITE) begin
			mem_we = 1'b1;
			if (hit_q) mem_wdata = {1'b1, tag_q, stamp_q, rins_hold_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sact_pkg::ST_CLEAR;
			clr_q    <= '0;
			cnt_q    <= '0;
			stamp_q  <= '0;
			hits_q   <= '0;
			misses_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				sact_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
				sact_pkg::ST_IDLE:  cnt_q <= '0;
				sact_pkg::ST_DIV, sact_pkg::ST_MOD: cnt_q <= (cnt_q == 6'd31) ? 6'd0 : cnt_q + 6'd1;
				sact_pkg::ST_RD:    cnt_q <= 6'd1;
				sact_pkg::ST_SCAN:  cnt_q <= cnt_q + 6'd1;
				sact_pkg::ST_WRITE: begin
					stamp_q <= stamp_q;
					if (hit_q) hits_q <= hits_q + 32'd1;
					else       misses_q <= misses_q + 32'd1;
				end
				sact_pkg::ST_OUT: ;
				default: ;
			endcase
			if (state_q == sact_pkg::ST_IDLE && s_tvalid) stamp_q <= stamp_q + 1'b1;
		end
	end

	// datapath: shared restoring divider, then way scan
	always_ff @(posedge clk) begin
		unique case (state_q)
			sact_pkg::ST_IDLE: begin
				quo_q <= s_tdata;
				rem_q <= '0;
			end
			sact_pkg::ST_DIV, sact_pkg::ST_MOD: begin
				if (!rem_sub[32]) begin
					rem_q <= rem_sub[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
				if (state_q == sact_pkg::ST_DIV && cnt_q == 6'd31) begin
					// quotient is the tag; restart for the modulo pass
					tag_q <= {quo_q[30:0], !rem_sub[32]};
					quo_q <= {quo_q[30:0], !rem_sub[32]};
					rem_q <= '0;
				end
				if (state_q == sact_pkg::ST_MOD && cnt_q == 6'd31)
					set_q <= SW'(!rem_sub[32] ? rem_sub[31:0] : rem_sh[31:0]);
			end
			sact_pkg::ST_RD: begin
				hit_q   <= 1'b0;
				found_q <= 1'b0;
				pick_q  <= '0;
			end
			sact_pkg::ST_SCAN: begin
				if (!hit_q) begin
					if (rv && rtag == tag_q) begin
						hit_q       <= 1'b1;
						pick_q      <= way_cur;
						rins_hold_q <= rins;
					end else if (!found_q) begin
						if (!rv) begin
							found_q <= 1'b1;
							pick_q  <= way_cur;
						end else if (cnt_q == 6'd1 || rkey < best_q) begin
							best_q <= rkey;
							pick_q <= way_cur;
						end
					end
				end
			end
			sact_pkg::ST_WRITE: begin
				out_q <= {6'd0, misses_q + {31'd0, !hit_q}, hits_q + {31'd0, hit_q}, tag_q,
					3'(pick_q), 6'(set_q), hit_q};
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sact_pkg::ST_IDLE) |-> !s_tready) else $error("ready while busy");
	a_out_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == sact_pkg::ST_WRITE) else $error("bad output entry");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sact_pkg::ST_WRITE) |=> (hits_q + misses_q) == $past(hits_q + misses_q) + 32'd1)
		else $error("counter step");
`endif
endmodule
`default_nettype wire
